FILE: rtl/fm_synth_register_shadow_writer_defines.svh
// Assertion helpers for the shadow writer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FM_SYNTH_REGISTER_SHADOW_WRITER_DEFINES_SVH
`define FM_SYNTH_REGISTER_SHADOW_WRITER_DEFINES_SVH

// Check a consequence in the same cycle as the antecedent
`define FSRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after the antecedent
`define FSRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fsrw_pkg.sv
package fsrw_pkg;

  // Sizes
  localparam int NUM_CHANNELS_DEF = 9;
  localparam int SHADOW_DEPTH     = 256;
  localparam int BYTE_W           = 8;
  localparam int ADDR_W           = 8;
  localparam int CHAN_W           = 4;
  localparam int CLK_W            = 20;
  localparam int MHZ_W            = 24;
  localparam int BLOCK_W          = 3;
  localparam int FNUM_W           = 10;
  localparam int MAX_SHIFT        = 20;
  localparam int SHIFT_W          = 5;
  localparam int WIDE_W           = MHZ_W + MAX_SHIFT;
  localparam int NUM_W            = 37;
  localparam int DVD_W            = NUM_W + 1;
  localparam int DEN_W            = 30;
  localparam int DIV_W            = DEN_W + 1;
  localparam int DIV_STEPS        = DVD_W;
  localparam int OVF_STEPS        = DVD_W - FNUM_W;
  localparam int CNT_W            = 6;

  // Constants
  localparam logic [CLK_W-1:0]  CLOCK_RESET  = 20'd49716;
  localparam logic [DEN_W-1:0]  DEN_SCALE    = 30'd1000;
  localparam logic [MHZ_W-1:0]  FREQ_MAX     = 24'd6208431;
  localparam logic [FNUM_W-1:0] FNUM_MAX     = 10'd1023;
  localparam logic [BYTE_W-1:0] KEY_BIT      = 8'h20;
  localparam logic [ADDR_W-1:0] FNUM_LO_BASE = 8'ha0;
  localparam logic [ADDR_W-1:0] FNUM_HI_BASE = 8'hb0;

  // Command codes
  localparam logic [1:0] ACT_MASKED_WRITE = 2'd0;
  localparam logic [1:0] ACT_SET_FREQ     = 2'd1;
  localparam logic [1:0] ACT_KEY_ON       = 2'd2;
  localparam logic [1:0] ACT_KEY_OFF      = 2'd3;

  // Kinds of chip write
  localparam logic [1:0] EMIT_MASK   = 2'd0;
  localparam logic [1:0] EMIT_KEYOFF = 2'd1;
  localparam logic [1:0] EMIT_LO     = 2'd2;
  localparam logic [1:0] EMIT_HI     = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] write_mask;
    logic [CHAN_W-1:0] channel;
    logic [MHZ_W-1:0]  freq_millihertz;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_addr;
    logic [BYTE_W-1:0] out_data;
    logic              last_write;
  } result_t;

  typedef struct packed {
    logic       cmd_load;
    logic       rd_issue;
    logic       rd_capture;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic [1:0] emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       ch_ok;
    logic       div_last;
  } ctrl_status_t;

  // Octave: count of thresholds the frequency exceeds
  function automatic logic [BLOCK_W-1:0] block_of(input logic [MHZ_W-1:0] mhz);
    logic [BLOCK_W-1:0] b;
    b = '0;
    if (mhz > 24'd48503)   b = 3'd1;
    if (mhz > 24'd97006)   b = 3'd2;
    if (mhz > 24'd194013)  b = 3'd3;
    if (mhz > 24'd388026)  b = 3'd4;
    if (mhz > 24'd776053)  b = 3'd5;
    if (mhz > 24'd1552107) b = 3'd6;
    if (mhz > 24'd3104215) b = 3'd7;
    return b;
  endfunction

endpackage

FILE: rtl/fsrw_ram.sv
module fsrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/fsrw_ctrl.sv
module fsrw_ctrl
  import fsrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ctrl_status_t status,
  output ctrl_cmd_t    ctl,
  output logic         busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADDR   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_MASK   = 3'd3;
  localparam logic [2:0] S_KEYOFF = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_LO     = 3'd6;
  localparam logic [2:0] S_HI     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequence one command through read, divide and write steps
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.cmd_load = 1'b1;
          state_next   = S_ADDR;
        end
      end
      S_ADDR: begin
        if (status.action != ACT_MASKED_WRITE && !status.ch_ok) begin
          // drop commands for channels that do not exist
          state_next = S_IDLE;
        end else begin
          ctl.rd_issue = 1'b1;
          ctl.div_init = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        ctl.rd_capture = 1'b1;
        unique case (status.action) inside
          ACT_MASKED_WRITE:         state_next = S_MASK;
          ACT_KEY_OFF:              state_next = S_KEYOFF;
          ACT_SET_FREQ, ACT_KEY_ON: state_next = S_DIV;
          default:                  state_next = S_IDLE;
        endcase
      end
      S_MASK: begin
        ctl.emit     = 1'b1;
        ctl.emit_sel = EMIT_MASK;
        state_next   = S_IDLE;
      end
      S_KEYOFF: begin
        ctl.emit     = 1'b1;
        ctl.emit_sel = EMIT_KEYOFF;
        state_next   = S_IDLE;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_LO;
        end
      end
      S_LO: begin
        ctl.emit     = 1'b1;
        ctl.emit_sel = EMIT_LO;
        state_next   = S_HI;
      end
      S_HI: begin
        ctl.emit     = 1'b1;
        ctl.emit_sel = EMIT_HI;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/fsrw_dp.sv
module fsrw_dp
  import fsrw_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             cfg_wr,
  input  logic [CLK_W-1:0] cfg_data,
  input  ctrl_cmd_t        ctl,
  output ctrl_status_t     status,
  output logic             result_valid,
  output result_t          result
);

  // Command and conversion operands
  cmd_t               cmd_q;
  logic [BLOCK_W-1:0] block_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;
  logic               f_zero;
  logic               f_high;
  logic               f_clkzero;
  logic [CLK_W-1:0]   chip_clock_hz;

  // Divider
  logic [DVD_W-1:0]   dvd;
  logic [DIV_W-1:0]   rem;
  logic [FNUM_W-1:0]  quo;
  logic               ovf;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   divisor;
  logic [DIV_W:0]     rem_sh;
  logic               qbit;

  // Shadow access
  logic [SHADOW_DEPTH-1:0] shadow_valid;
  logic                    rd_valid;
  logic [BYTE_W-1:0]       ram_rdata;
  logic [BYTE_W-1:0]       old_byte;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       lo_addr;
  logic [ADDR_W-1:0]       hi_addr;
  logic [CHAN_W-1:0]       ch_off;
  logic [ADDR_W-1:0]       wr_addr;
  logic [BYTE_W-1:0]       wr_data;
  logic                    wr_last;
  logic [FNUM_W-1:0]       fnum;
  logic [BLOCK_W-1:0]      in_block;
  logic [WIDE_W-1:0]       num_wide;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_clock_hz <= CLOCK_RESET;
    end else if (cfg_wr) begin
      chip_clock_hz <= cfg_data;
    end
  end

  // Octave and scaled numerator of the incoming command
  assign in_block = block_of(cmd.freq_millihertz);
  assign num_wide = WIDE_W'(cmd.freq_millihertz)
                    << (SHIFT_W'(MAX_SHIFT) - SHIFT_W'(in_block));

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (ctl.cmd_load) begin
      cmd_q     <= cmd;
      block_q   <= in_block;
      num_q     <= num_wide[NUM_W-1:0];
      den_q     <= DEN_W'(chip_clock_hz) * DEN_SCALE;
      f_zero    <= (cmd.freq_millihertz == '0);
      f_high    <= (cmd.freq_millihertz > FREQ_MAX);
      f_clkzero <= (chip_clock_hz == '0);
    end
  end

  // Channel decode
  assign ch_off  = cmd_q.channel - 1'b1;
  assign lo_addr = FNUM_LO_BASE + ADDR_W'(ch_off);
  assign hi_addr = FNUM_HI_BASE + ADDR_W'(ch_off);
  assign rd_addr = (cmd_q.action == ACT_MASKED_WRITE) ? cmd_q.reg_addr : hi_addr;

  assign status.action   = cmd_q.action;
  assign status.ch_ok    = (cmd_q.channel != '0) &&
                           (cmd_q.channel <= CHAN_W'(NUM_CHANNELS));
  assign status.div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // Restoring division, one quotient bit per cycle
  assign divisor = {den_q, 1'b0};
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      dvd <= {num_q, 1'b0} + DVD_W'(den_q);
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
      cnt <= '0;
    end else if (ctl.div_step) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= qbit ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
      quo <= {quo[FNUM_W-2:0], qbit};
      // any quotient bit above the fnum range saturates
      ovf <= ovf | (qbit && (cnt < CNT_W'(OVF_STEPS)));
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    if (f_zero) begin
      fnum = '0;
    end else if (f_high || f_clkzero || ovf) begin
      fnum = FNUM_MAX;
    end else begin
      fnum = quo;
    end
  end

  // Shadow memory; never-written entries read as zero
  fsrw_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SHADOW_DEPTH)
  ) u_shadow (
    .clk    (clk),
    .wr_en  (ctl.emit),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.rd_issue),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_valid <= '0;
    end else if (ctl.emit) begin
      shadow_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_valid <= shadow_valid[rd_addr];
    end
    if (ctl.rd_capture) begin
      old_byte <= rd_valid ? ram_rdata : '0;
    end
  end

  // Build the chip write
  always_comb begin
    case (ctl.emit_sel)
      EMIT_MASK: begin
        wr_addr = cmd_q.reg_addr;
        wr_data = (cmd_q.write_mask == '0) ? cmd_q.write_value :
                  ((old_byte & ~cmd_q.write_mask) |
                   (cmd_q.write_value & cmd_q.write_mask));
        wr_last = 1'b1;
      end
      EMIT_KEYOFF: begin
        wr_addr = hi_addr;
        wr_data = old_byte & ~KEY_BIT;
        wr_last = 1'b1;
      end
      EMIT_LO: begin
        wr_addr = lo_addr;
        wr_data = fnum[BYTE_W-1:0];
        wr_last = 1'b0;
      end
      default: begin
        wr_addr = hi_addr;
        wr_data = (old_byte & KEY_BIT)
                | ((cmd_q.action == ACT_KEY_ON) ? KEY_BIT : '0)
                | {3'b000, block_q, fnum[FNUM_W-1:BYTE_W]};
        wr_last = 1'b1;
      end
    endcase
  end

  // Output register; each write is flagged by result_valid for a single cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.out_addr   <= wr_addr;
      result.out_data   <= wr_data;
      result.last_write <= wr_last;
    end
  end

endmodule

FILE: rtl/fm_synth_register_shadow_writer.sv
// FM-synth register shadow writer.
// Commands enter on cmd and are taken at a clock edge where start is high
// and busy is low. Each chip register write comes out on result for exactly
// one cycle with result_valid high; the receiver has no way to hold it off.
// A masked write or a key-off gives one write, registered after the
// address, fetch and mask or key-off states; the block is idle again
// as that write comes out. Set-frequency and key-on give two writes,
// fnum low byte then block/key byte, from the low and high write states
// after the divide state; the restoring divider producing fnum takes one
// quotient bit per cycle. A set-frequency, key-on or key-off command for
// a channel outside 1..NUM_CHANNELS gives no write.
// chip_clock_hz is written on the cfg channel while the block is idle.
// Reset sets chip_clock_hz to 49716 and makes every shadow entry read as
// zero at once through per-entry valid bits; there is no clearing pass.
`include "fm_synth_register_shadow_writer_defines.svh"

module fm_synth_register_shadow_writer
  import fsrw_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             result_valid,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CLK_W-1:0] cfg_data
);

  ctrl_cmd_t    ctl;
  ctrl_status_t status;

  assign cfg_ready = ~busy;

  fsrw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .ctl   (ctl),
    .busy  (busy)
  );

  fsrw_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .status      (status),
    .result_valid(result_valid),
    .result      (result)
  );

  // A frequency transaction's low byte is always followed by its final write
  `FSRW_ASSERT_NEXT(a_lo_then_hi, result_valid && !result.last_write, result_valid && result.last_write, "fnum low write not followed by final write")
  // The final write of a transaction appears once the controller is idle
  `FSRW_ASSERT_NOW(a_last_idle, result_valid && result.last_write, !busy, "final write seen while busy")
  // An accepted transaction keeps the block busy on the next cycle
  `FSRW_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid, "accepted transaction did not raise busy")

endmodule

FILE: tb/fm_synth_register_shadow_writer_tb.sv
module fm_synth_register_shadow_writer_tb;
  import fsrw_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 6;
  // Row count meaning "work it out from the shadow mirror"
  localparam int PREDICT         = -1;

  typedef struct {
    cmd_t    cmd;
    int      count;
    result_t first;
    result_t second;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             result_valid;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CLK_W-1:0] cfg_data;

  // Mirror of the chip register shadow and the clock register
  logic [BYTE_W-1:0] shadow_copy [SHADOW_DEPTH];
  logic [CLK_W-1:0]  chip_clock;
  logic [MHZ_W-1:0]  octave_edge [7] = '{24'd48503, 24'd97006, 24'd194013, 24'd388026,
                                        24'd776053, 24'd1552107, 24'd3104215};

  result_t     chip_write_queue [$];
  stim_row_t   directed_rows [$];
  bit          gaps_on = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  fm_synth_register_shadow_writer i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Convert millihertz to octave block and rounded fnum
  function automatic void freq_to_fnum(input logic [MHZ_W-1:0] mhz,
                                       output logic [FNUM_W-1:0] fnum,
                                       output logic [BLOCK_W-1:0] blk);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    blk = '0;
    fnum = '0;
    if (mhz == '0) return;
    if (mhz > FREQ_MAX) begin
      blk = 3'd7;
      fnum = FNUM_MAX;
      return;
    end
    for (int i = 0; i < 7; i++) begin
      if (mhz > octave_edge[i]) blk = BLOCK_W'(i + 1);
    end
    // zero clock saturates without dividing
    if (chip_clock == '0) begin
      fnum = FNUM_MAX;
      return;
    end
    num = 64'(mhz) << (MAX_SHIFT - int'(blk));
    den = 64'(chip_clock) * 64'd1000;
    quot = (64'd2 * num + den) / (64'd2 * den);
    fnum = (quot > 64'(FNUM_MAX)) ? FNUM_MAX : quot[FNUM_W-1:0];
  endfunction

  // Apply one command to the mirror and return the chip writes it causes
  function automatic int apply_command(input cmd_t c, output result_t w0, output result_t w1);
    logic [ADDR_W-1:0]  lo_addr;
    logic [ADDR_W-1:0]  hi_addr;
    logic [BYTE_W-1:0]  data;
    logic [FNUM_W-1:0]  fnum;
    logic [BLOCK_W-1:0] blk;
    w0 = '0;
    w1 = '0;
    if (c.action == ACT_MASKED_WRITE) begin
      data = c.write_value;
      if (c.write_mask != '0) begin
        data = (shadow_copy[c.reg_addr] & ~c.write_mask) | (c.write_value & c.write_mask);
      end
      shadow_copy[c.reg_addr] = data;
      w0 = {c.reg_addr, data, 1'b1};
      return 1;
    end
    if (c.channel < 1 || c.channel > NUM_CHANNELS_DEF) return 0;
    lo_addr = FNUM_LO_BASE + ADDR_W'(c.channel - 1);
    hi_addr = FNUM_HI_BASE + ADDR_W'(c.channel - 1);
    if (c.action == ACT_KEY_OFF) begin
      data = shadow_copy[hi_addr] & ~KEY_BIT;
      shadow_copy[hi_addr] = data;
      w0 = {hi_addr, data, 1'b1};
      return 1;
    end
    freq_to_fnum(c.freq_millihertz, fnum, blk);
    shadow_copy[lo_addr] = fnum[7:0];
    w0 = {lo_addr, fnum[7:0], 1'b0};
    // keep the stored key bit, set it on key-on
    data = (shadow_copy[hi_addr] & KEY_BIT) | ((c.action == ACT_KEY_ON) ? KEY_BIT : 8'h00)
           | {3'b000, blk, fnum[9:8]};
    shadow_copy[hi_addr] = data;
    w1 = {hi_addr, data, 1'b1};
    return 2;
  endfunction

  function automatic cmd_t noise_cmd();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(cmd_t)-1:0];
  endfunction

  // Bias frequencies toward zero, saturation and octave edges
  function automatic logic [MHZ_W-1:0] random_freq();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return FREQ_MAX + MHZ_W'($urandom_range(1));
      3, 4: return octave_edge[$urandom_range(6)] + MHZ_W'($urandom_range(2)) - MHZ_W'(1);
      5: return r[MHZ_W-1:0];
      6, 7: return MHZ_W'(r >> $urandom_range(8, 31));
      default: return MHZ_W'($urandom_range(20000, 6208431));
    endcase
  endfunction

  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    c = noise_cmd();
    pick = $urandom_range(99);
    if (pick < 30) c.action = ACT_MASKED_WRITE;
    else if (pick < 55) c.action = ACT_SET_FREQ;
    else if (pick < 80) c.action = ACT_KEY_ON;
    else c.action = ACT_KEY_OFF;
    // mostly valid channels, the rest left as raw noise
    if ($urandom_range(9) != 0) c.channel = CHAN_W'($urandom_range(1, NUM_CHANNELS_DEF));
    // aim half the masked writes at the fnum and key registers
    if ($urandom_range(1) == 0) begin
      c.reg_addr = ($urandom_range(1) ? FNUM_HI_BASE : FNUM_LO_BASE) + ADDR_W'($urandom_range(8));
    end
    case ($urandom_range(3))
      0: c.write_mask = '0;
      1: c.write_mask = KEY_BIT;
      default: ;
    endcase
    c.freq_millihertz = random_freq();
    return c;
  endfunction

  function automatic void add_row(input cmd_t c, input int count,
                                  input result_t first, input result_t second);
    directed_rows.push_back('{c, count, first, second});
  endfunction

  // Drive one command, wait for the transaction and queue its chip writes
  task automatic issue_command(input cmd_t c, input int typed_count, input result_t first,
                               input result_t second, output int n);
    result_t w0;
    result_t w1;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      cmd <= noise_cmd();
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = apply_command(c, w0, w1);
    if (typed_count != PREDICT) begin
      n = typed_count;
      w0 = first;
      w1 = second;
    end
    if (n > 0) chip_write_queue.push_back(w0);
    if (n > 1) chip_write_queue.push_back(w1);
  endtask

  // Drop start, wait for every queued write, then let the block settle
  task automatic drain_writes();
    @(negedge clk);
    start <= 1'b0;
    while (chip_write_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chip_clock(input logic [CLK_W-1:0] value);
    drain_writes();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chip_clock = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Check each chip write against the oldest expected one
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (chip_write_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected chip write: addr=%h data=%h last=%b",
                   result.out_addr, result.out_data, result.last_write);
        end
      end else begin
        want = chip_write_queue.pop_front();
        if (result.out_addr !== want.out_addr || result.out_data !== want.out_data ||
            result.last_write !== want.last_write) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("chip write mismatch: expected addr=%h data=%h last=%b, got addr=%h data=%h last=%b",
                     want.out_addr, want.out_data, want.last_write,
                     result.out_addr, result.out_data, result.last_write);
          end
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("fm_synth_register_shadow_writer_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t        row;
    cmd_t             c;
    int               n;
    int unsigned      sent;
    logic [CLK_W-1:0] clock_plan [NUM_PHASES];
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    chip_clock = CLOCK_RESET;
    foreach (shadow_copy[i]) shadow_copy[i] = '0;

    // Directed commands at the reset clock value
    add_row({ACT_MASKED_WRITE, 8'h00, 8'hff, 8'h00, 4'd0, 24'd0}, 1,
            {8'h00, 8'hff, 1'b1}, '0);
    add_row({ACT_MASKED_WRITE, 8'hff, 8'ha5, 8'h0f, 4'd0, 24'd0}, 1,
            {8'hff, 8'h05, 1'b1}, '0);
    add_row({ACT_MASKED_WRITE, 8'hff, 8'h5a, 8'hf0, 4'd0, 24'd0}, 1,
            {8'hff, 8'h55, 1'b1}, '0);
    add_row({ACT_MASKED_WRITE, 8'h7f, 8'h00, 8'hff, 4'd0, 24'd0}, 1,
            {8'h7f, 8'h00, 1'b1}, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd1, 24'd0}, 2,
            {8'ha0, 8'h00, 1'b0}, {8'hb0, 8'h00, 1'b1});
    add_row({ACT_KEY_ON, 8'h00, 8'h00, 8'h00, 4'd9, 24'd0}, 2,
            {8'ha8, 8'h00, 1'b0}, {8'hb8, 8'h20, 1'b1});
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd9, 24'hffffff}, 2,
            {8'ha8, 8'hff, 1'b0}, {8'hb8, 8'h3f, 1'b1});
    add_row({ACT_KEY_OFF, 8'h00, 8'h00, 8'h00, 4'd9, 24'd0}, 1,
            {8'hb8, 8'h1f, 1'b1}, '0);
    add_row({ACT_KEY_OFF, 8'hb0, 8'hff, 8'hff, 4'd0, 24'd0}, 0, '0, '0);
    add_row({ACT_SET_FREQ, 8'ha0, 8'h00, 8'h00, 4'd10, 24'd440000}, 0, '0, '0);
    add_row({ACT_KEY_ON, 8'h00, 8'h00, 8'h00, 4'd15, 24'hffffff}, 0, '0, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd1, 24'd6208431}, PREDICT, '0, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd2, 24'd6208432}, 2,
            {8'ha1, 8'hff, 1'b0}, {8'hb1, 8'h1f, 1'b1});
    add_row({ACT_KEY_ON, 8'h00, 8'h00, 8'h00, 4'd3, 24'd48503}, PREDICT, '0, '0);
    add_row({ACT_KEY_ON, 8'h00, 8'h00, 8'h00, 4'd4, 24'd48504}, PREDICT, '0, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd5, 24'd3104215}, PREDICT, '0, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd6, 24'd3104216}, PREDICT, '0, '0);
    add_row({ACT_MASKED_WRITE, 8'hb6, 8'hff, 8'h20, 4'd0, 24'd0}, 1,
            {8'hb6, 8'h20, 1'b1}, '0);
    add_row({ACT_SET_FREQ, 8'h00, 8'h00, 8'h00, 4'd7, 24'd440000}, PREDICT, '0, '0);
    add_row({ACT_KEY_OFF, 8'h00, 8'h00, 8'h00, 4'd7, 24'd0}, PREDICT, '0, '0);
    add_row({ACT_KEY_ON, 8'h00, 8'h00, 8'h00, 4'd8, 24'd1}, PREDICT, '0, '0);
    add_row({ACT_MASKED_WRITE, 8'ha0, 8'h3c, 8'h00, 4'd15, 24'hffffff}, 1,
            {8'ha0, 8'h3c, 1'b1}, '0);
    add_row({ACT_KEY_OFF, 8'h00, 8'h00, 8'h00, 4'd1, 24'd0}, PREDICT, '0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      issue_command(row.cmd, row.count, row.first, row.second, n);
    end

    // Random commands under a series of clock settings, one phase without gaps
    clock_plan = '{20'd1000, 20'd1000000, 20'd0, 20'hfffff,
                   CLK_W'($urandom_range(1000, 1000000)), CLOCK_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_chip_clock(clock_plan[p]);
      gaps_on = (p != 1);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        c = random_command();
        issue_command(c, PREDICT, '0, '0, n);
        if (n > 0) sent++;
      end
    end

    drain_writes();
    if (mismatch_count == 0) begin
      $display("fm_synth_register_shadow_writer_tb OK");
    end else begin
      $display("fm_synth_register_shadow_writer_tb NOT OK");
    end
    $finish;
  end

endmodule
